// File: rtl/spgd_pkg.sv
package spgd_pkg;

    localparam int MAX_WIDTH   = 32;
    localparam int ACC_BITS    = 40;
    localparam int BYTE_W      = 8;
    localparam int CNT_W       = $clog2(ACC_BITS + 1);
    localparam int PW_W        = 6;
    localparam int N_W         = MAX_WIDTH;
    localparam int VAL_W       = 64;
    localparam int SCALE_W     = 63;
    localparam int SPLIT_W     = 32;
    localparam int P0_W        = N_W + SPLIT_W;
    localparam int P1_W        = N_W + SCALE_W - SPLIT_W;
    localparam int SUM_W       = VAL_W + 2;
    localparam int HI_W        = P1_W + 2;
    localparam int FIFO_DEPTH  = 8;
    localparam int PTR_W       = $clog2(FIFO_DEPTH);
    localparam int IN_TDATA_W  = 16;
    localparam int OUT_TDATA_W = 72;
    localparam int CFG_IDX_W   = 2;

    localparam logic [SCALE_W-1:0] SCALE_RESET = SCALE_W'(64'h0000_0001_0000_0000);

    typedef enum logic [1:0] {
        ST_VALUE,
        ST_MISSING,
        ST_UNDERFLOW,
        ST_OVERFLOW
    } t_status;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PACK_WIDTH,
        CFG_REF_VALUE,
        CFG_SCALE,
        CFG_MISSING_VALUE
    } t_cfg_idx;

    typedef struct packed {
        logic           valid;
        logic           has_result;
        t_status        status;
        logic           last;
        logic [N_W-1:0] n;
    } t_unpk;

    typedef struct packed {
        logic             valid;
        logic             has_result;
        t_status          status;
        logic             last;
    } t_meta;

    typedef struct packed {
        logic [VAL_W-1:0] value;
        logic             saturated;
        t_status          status;
        logic             last;
    } t_result;

endpackage

// File: rtl/spgd_unpack.sv
module spgd_unpack (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_accept,
    input  logic                          i_command,
    input  logic [spgd_pkg::BYTE_W-1:0]   i_data_byte,
    input  logic                          i_present,
    input  logic                          i_last_point,
    input  logic [spgd_pkg::PW_W-1:0]     i_pack_width,
    output spgd_pkg::t_unpk               o_item
);
    import spgd_pkg::*;

    logic [ACC_BITS-1:0] r_acc, n_acc;
    logic [CNT_W-1:0]    r_cnt, n_cnt, rem;
    logic [PW_W-1:0]     w;
    logic [CNT_W:0]      cnt_plus;
    logic [ACC_BITS-1:0] shifted, keep;
    logic [ACC_BITS:0]   keep_one;
    logic [N_W:0]        mask_one;
    logic [N_W-1:0]      field;
    t_unpk               r_item, n_item;

    always_comb begin
        w        = (i_pack_width > PW_W'(MAX_WIDTH)) ? PW_W'(MAX_WIDTH) : i_pack_width;
        cnt_plus = {1'b0, r_cnt} + (CNT_W+1)'(BYTE_W);
        rem      = r_cnt - CNT_W'(w);
        shifted  = r_acc >> rem;
        mask_one = (N_W+1)'(1) << w;
        field    = shifted[N_W-1:0] & N_W'(mask_one - 1'b1);
        keep_one = (ACC_BITS+1)'(1) << rem;
        keep     = ACC_BITS'(keep_one - 1'b1);

        n_acc        = r_acc;
        n_cnt        = r_cnt;
        n_item       = '0;
        n_item.valid = i_accept;

        if (!i_command) begin
            if (cnt_plus > (CNT_W+1)'(ACC_BITS)) begin
                n_item.has_result = 1'b1;
                n_item.status     = ST_OVERFLOW;
            end else begin
                n_acc = {r_acc[ACC_BITS-BYTE_W-1:0], i_data_byte};
                n_cnt = cnt_plus[CNT_W-1:0];
            end
        end else begin
            n_item.has_result = 1'b1;
            n_item.last       = i_last_point;
            if (!i_present) begin
                n_item.status = ST_MISSING;
            end else if (w == '0) begin
                n_item.status = ST_VALUE;
            end else if (r_cnt < CNT_W'(w)) begin
                n_item.status = ST_UNDERFLOW;
            end else begin
                n_item.status = ST_VALUE;
                n_item.n      = field;
                n_cnt         = rem;
                n_acc         = r_acc & keep;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc  <= '0;
            r_cnt  <= '0;
            r_item <= '0;
        end else begin
            r_item <= n_item;
            if (i_accept) begin
                r_acc <= n_acc;
                r_cnt <= n_cnt;
            end
        end
    end

    assign o_item = r_item;

endmodule

// File: rtl/spgd_muladd.sv
module spgd_muladd (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  spgd_pkg::t_unpk               i_item,
    input  logic [spgd_pkg::SCALE_W-1:0]  i_scale,
    input  logic [spgd_pkg::VAL_W-1:0]    i_ref_value,
    input  logic [spgd_pkg::VAL_W-1:0]    i_missing_value,
    output logic                          o_push,
    output spgd_pkg::t_result             o_res,
    output logic [1:0]                    o_busy
);
    import spgd_pkg::*;

    t_meta             r2_meta, r3_meta;
    logic [P0_W-1:0]   r2_p0;
    logic [P1_W-1:0]   r2_p1, r3_p1;
    logic [SUM_W-1:0]  r3_sum;
    logic [HI_W-1:0]   hi;
    logic [HI_W-VAL_W+SPLIT_W:0] top;
    logic              fits;

    // stage 2: partial products of the 32-bit field and the two scale halves
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_meta <= '0;
            r3_meta <= '0;
        end else begin
            r2_meta <= '{valid: i_item.valid, has_result: i_item.has_result,
                         status: i_item.status, last: i_item.last};
            r3_meta <= r2_meta;
        end
    end

    always_ff @(posedge i_clk) begin
        r2_p0  <= P0_W'(i_item.n) * P0_W'(i_scale[SPLIT_W-1:0]);
        r2_p1  <= P1_W'(i_item.n) * P1_W'(i_scale[SCALE_W-1:SPLIT_W]);
        // stage 3: reference plus low partial product
        r3_sum <= {{(SUM_W-VAL_W){i_ref_value[VAL_W-1]}}, i_ref_value}
                  + {{(SUM_W-P0_W){1'b0}}, r2_p0};
        r3_p1  <= r2_p1;
    end

    // stage 4: high partial product folded in, then range check
    always_comb begin
        hi   = {{(HI_W-(SUM_W-SPLIT_W)){r3_sum[SUM_W-1]}}, r3_sum[SUM_W-1:SPLIT_W]}
               + {{(HI_W-P1_W){1'b0}}, r3_p1};
        top  = hi[HI_W-1:VAL_W-SPLIT_W-1];
        fits = (&top) | ~(|top);

        o_res.status    = r3_meta.status;
        o_res.last      = r3_meta.last;
        o_res.saturated = 1'b0;
        case (r3_meta.status)
            ST_VALUE: begin
                if (fits) begin
                    o_res.value = {hi[VAL_W-SPLIT_W-1:0], r3_sum[SPLIT_W-1:0]};
                end else begin
                    o_res.saturated = 1'b1;
                    o_res.value     = hi[HI_W-1] ? {1'b1, {(VAL_W-1){1'b0}}}
                                                 : {1'b0, {(VAL_W-1){1'b1}}};
                end
            end
            ST_MISSING: o_res.value = i_missing_value;
            default:    o_res.value = '0;
        endcase
    end

    assign o_push = r3_meta.valid & r3_meta.has_result;
    assign o_busy = {1'b0, r2_meta.valid} + {1'b0, r3_meta.valid};

endmodule

// File: rtl/spgd_fifo.sv
module spgd_fifo (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_push,
    input  spgd_pkg::t_result              i_data,
    output logic                           o_valid,
    input  logic                           i_ready,
    output spgd_pkg::t_result              o_data,
    output logic [spgd_pkg::PTR_W:0]       o_count
);
    import spgd_pkg::*;

    t_result          r_mem [FIFO_DEPTH];
    logic [PTR_W-1:0] r_wr, r_rd;
    logic [PTR_W:0]   r_count;
    logic             pop;

    assign o_valid = (r_count != '0);
    assign pop     = o_valid & i_ready;
    assign o_data  = r_mem[r_rd];
    assign o_count = r_count;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (pop) begin
                r_rd <= r_rd + 1'b1;
            end
            case ({i_push, pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

// File: rtl/simple_packing_grid_decoder.sv
// Path: unpack register, multiply-add stages 2 and 3, then the result queue before m_axis.
// Throughput: one word per cycle; results queue in an 8-entry buffer, and s_axis_tready
// drops while eight words sit in the pipeline and queue together.
// Reset (synchronous, i_rst_n low) empties pipeline and queue, clears the bit
// accumulator and returns the registers to width 0, reference 0, scale 1.0, missing 0.
module simple_packing_grid_decoder (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    input  logic [spgd_pkg::IN_TDATA_W-1:0]    s_axis_tdata,  // data_byte[7:0], present[8]
    input  logic                               s_axis_tuser,  // command
    input  logic                               s_axis_tlast,
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    output logic [spgd_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,  // value[63:0], saturated[64]
    output logic [1:0]                         m_axis_tuser,  // status
    output logic                               m_axis_tlast,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [spgd_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [spgd_pkg::VAL_W-1:0]         i_cfg_data
);
    import spgd_pkg::*;

    logic [PW_W-1:0]    r_pack_width;
    logic [VAL_W-1:0]   r_ref_value, r_missing_value;
    logic [SCALE_W-1:0] r_scale;

    t_unpk              item;
    t_result            res, out_res;
    logic               push, accept;
    logic [1:0]         busy;
    logic [PTR_W:0]     fifo_count, total;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pack_width    <= '0;
            r_ref_value     <= '0;
            r_scale         <= SCALE_RESET;
            r_missing_value <= '0;
        end else if (i_cfg_valid) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_PACK_WIDTH:    r_pack_width    <= i_cfg_data[PW_W-1:0];
                CFG_REF_VALUE:     r_ref_value     <= i_cfg_data;
                CFG_SCALE:         r_scale         <= i_cfg_data[SCALE_W-1:0];
                CFG_MISSING_VALUE: r_missing_value <= i_cfg_data;
                default:           r_pack_width    <= r_pack_width;
            endcase
        end
    end

    assign total         = {{PTR_W{1'b0}}, item.valid} + {{(PTR_W-1){1'b0}}, busy}
                           + fifo_count;
    assign s_axis_tready = (total < (PTR_W+1)'(FIFO_DEPTH));
    assign accept        = s_axis_tvalid & s_axis_tready;

    spgd_unpack u_unpack (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_accept     (accept),
        .i_command    (s_axis_tuser),
        .i_data_byte  (s_axis_tdata[BYTE_W-1:0]),
        .i_present    (s_axis_tdata[BYTE_W]),
        .i_last_point (s_axis_tlast),
        .i_pack_width (r_pack_width),
        .o_item       (item)
    );

    spgd_muladd u_muladd (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_item          (item),
        .i_scale         (r_scale),
        .i_ref_value     (r_ref_value),
        .i_missing_value (r_missing_value),
        .o_push          (push),
        .o_res           (res),
        .o_busy          (busy)
    );

    spgd_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (res),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_data  (out_res),
        .o_count (fifo_count)
    );

    assign m_axis_tdata = {{(OUT_TDATA_W-VAL_W-1){1'b0}}, out_res.saturated, out_res.value};
    assign m_axis_tuser = out_res.status;
    assign m_axis_tlast = out_res.last;

    a_credit_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        total <= (PTR_W+1)'(FIFO_DEPTH))
        else $error("pipeline and queue hold more words than the queue depth");

    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fifo_count == (PTR_W+1)'(FIFO_DEPTH) |-> !push)
        else $error("result pushed into full queue");

    a_sat_is_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[VAL_W] |-> m_axis_tuser == ST_VALUE)
        else $error("saturation flagged on non-value word");

    a_no_stall_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !item.valid && busy == 2'd0 && fifo_count == '0 |-> s_axis_tready)
        else $error("input stalled with nothing in flight");

endmodule
